@@ hw/rtl/gpe_pkg.sv @@
// ----------------------------------------------------------------------------
// gpe_pkg
// shared types and constants of the glyph pixel expander
// ----------------------------------------------------------------------------
`default_nettype none

package gpe_pkg;

  localparam int OFFSET_W    = 27;
  localparam int COLOR_W     = 24;
  localparam int POS_W       = 12;
  localparam int PITCH_W     = 15;
  localparam int BPP_W       = 3;
  localparam int DIM_W       = 4;
  localparam int BYTE_W      = 8;
  localparam int CODE_W      = 8;
  localparam int STORE_AW    = 11;
  localparam int STORE_DEPTH = 2048;
  localparam int PRODX_W     = POS_W + BPP_W;
  localparam int PRODY_W     = POS_W + PITCH_W;

  // highest bit of a glyph row byte, used for the mirrored column order
  localparam logic [2:0] BIT_MSB = 3'd7;

  // operations of the offset unit
  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_BASE = 2'd1,
    OP_COL  = 2'd2,
    OP_ROW  = 2'd3
  } off_op_t;

  typedef struct packed {
    logic    en;
    off_op_t op;
  } off_ctl_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_ROW_PITCH    = 3'd0,
    REG_BYTES_PER_PX = 3'd1,
    REG_MIRROR_BITS  = 3'd2,
    REG_GLYPH_WIDTH  = 3'd3,
    REG_GLYPH_HEIGHT = 3'd4,
    REG_GLYPH_STRIDE = 3'd5
  } cfg_reg_t;

endpackage

`default_nettype wire

@@ hw/rtl/gpe_glyph_store.sv @@
// ----------------------------------------------------------------------------
// gpe_glyph_store
// glyph bitmap store, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module gpe_glyph_store (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [gpe_pkg::STORE_AW-1:0]  waddr,
  input  wire logic [gpe_pkg::BYTE_W-1:0]    wdata,
  input  wire logic                          re,
  input  wire logic [gpe_pkg::STORE_AW-1:0]  raddr,
  output logic      [gpe_pkg::BYTE_W-1:0]    rdata
);
  import gpe_pkg::*;

  logic [BYTE_W-1:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/gpe_offset_unit.sv @@
// ----------------------------------------------------------------------------
// gpe_offset_unit
// frame byte offset generator built round one shared 27-bit adder
// ----------------------------------------------------------------------------
`default_nettype none

module gpe_offset_unit (
  input  wire logic                          clk,
  input  wire gpe_pkg::off_ctl_t             ctl,
  input  wire logic [gpe_pkg::POS_W-1:0]     pos_x,
  input  wire logic [gpe_pkg::POS_W-1:0]     pos_y,
  input  wire logic [gpe_pkg::BPP_W-1:0]     bytes_per_pixel,
  input  wire logic [gpe_pkg::PITCH_W-1:0]   row_pitch,
  output logic      [gpe_pkg::OFFSET_W-1:0]  offset
);
  import gpe_pkg::*;

  logic [PRODX_W-1:0]  prod_x;
  logic [PRODY_W-1:0]  prod_y;
  logic [OFFSET_W-1:0] row_base;
  logic [OFFSET_W-1:0] add_a;
  logic [OFFSET_W-1:0] add_b;
  logic [OFFSET_W-1:0] sum;

  // operand selection for the shared adder
  always_comb begin
    case (ctl.op)
      OP_BASE: begin
        add_a = OFFSET_W'(prod_x);
        add_b = OFFSET_W'(prod_y);
      end
      OP_ROW: begin
        add_a = row_base;
        add_b = OFFSET_W'(row_pitch);
      end
      OP_COL: begin
        add_a = offset;
        add_b = OFFSET_W'(bytes_per_pixel);
      end
      default: begin
        add_a = offset;
        add_b = '0;
      end
    endcase
    sum = add_a + add_b;
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      case (ctl.op)
        OP_MUL: begin
          prod_x <= PRODX_W'(pos_x) * PRODX_W'(bytes_per_pixel);
          prod_y <= PRODY_W'(pos_y) * PRODY_W'(row_pitch);
        end
        OP_BASE, OP_ROW: begin
          row_base <= sum;
          offset   <= sum;
        end
        OP_COL: begin
          offset <= sum;
        end
        default: begin
          offset <= offset;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/glyph_pixel_expander_top.sv @@
// ----------------------------------------------------------------------------
// glyph_pixel_expander_top
// bitmap font character generator with a loadable glyph store
// ----------------------------------------------------------------------------
// A load word (tuser 0) writes one byte of the 2048-byte glyph store in the
// cycle it is taken. A draw word (tuser 1) expands one character into one
// output word per glyph pixel, row by row and column by column, each carrying
// the frame byte offset and the foreground or background colour; tlast marks
// the final pixel. A draw sets up the multiplies as it is taken, forms the base
// offset in a base state, then emits one pixel per cycle through the single
// offset adder, slower if the output stalls; a draw with zero width or height
// produces nothing. The input is not ready during a draw. Glyph bytes must be
// loaded before they are drawn; the store has no reset and unloaded entries
// read as garbage.
`default_nettype none

module glyph_pixel_expander_top #(
  parameter int MAX_GLYPH_WIDTH  = 8,
  parameter int MAX_GLYPH_HEIGHT = 8,
  parameter int CHAR_COUNT       = 256
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // stream in
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // store_address, store_byte, char_code, pos_x, pos_y, fore_color, back_color
  input  wire logic [103:0] s_axis_tdata,
  // action
  input  wire logic [0:0]   s_axis_tuser,
  // stream out
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // frame_offset, pixel_color
  output logic [55:0]       m_axis_tdata,
  output logic              m_axis_tlast,
  // configuration
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [4:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import gpe_pkg::*;

  localparam int CW = $clog2(MAX_GLYPH_WIDTH + 1);
  localparam int RW = $clog2(MAX_GLYPH_HEIGHT + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BASE,
    ST_RUN
  } state_t;

  // configuration registers
  logic [PITCH_W-1:0] row_pitch;
  logic [BPP_W-1:0]   bytes_per_pixel;
  logic               mirror_bits;
  logic [DIM_W-1:0]   glyph_width;
  logic [DIM_W-1:0]   glyph_height;
  logic [DIM_W-1:0]   glyph_stride;

  // input fields
  logic                in_action;
  logic [STORE_AW-1:0] in_store_address;
  logic [BYTE_W-1:0]   in_store_byte;
  logic [CODE_W-1:0]   in_char_code;
  logic [POS_W-1:0]    in_pos_x;
  logic [POS_W-1:0]    in_pos_y;
  logic [COLOR_W-1:0]  in_fore_color;
  logic [COLOR_W-1:0]  in_back_color;

  state_t              state;
  logic [CW-1:0]       col;
  logic [RW-1:0]       row;
  logic [STORE_AW-1:0] char_base;
  logic [STORE_AW-1:0] glyph_addr;
  logic [COLOR_W-1:0]  fore_color;
  logic [COLOR_W-1:0]  back_color;

  logic [OFFSET_W-1:0] out_offset;
  logic [COLOR_W-1:0]  out_color;
  logic                out_last;
  logic                out_valid;

  logic [CW-1:0]       w_eff;
  logic [RW-1:0]       h_eff;
  logic                accept;
  logic                draw_go;
  logic                emit;
  logic                col_last;
  logic                row_last;
  logic                pix_last;
  logic [CODE_W-1:0]   code_mod;
  logic [2:0]          col3;
  logic [2:0]          bit_idx;
  logic                pix_on;
  logic                cfg_wr;
  cfg_reg_t            cfg_sel;
  off_ctl_t            off_ctl;
  logic                st_re;
  logic [STORE_AW-1:0] st_raddr;
  logic [BYTE_W-1:0]   row_bits;
  logic [OFFSET_W-1:0] cur_offset;

  assign in_action        = s_axis_tuser[0];
  assign in_store_address = s_axis_tdata[10:0];
  assign in_store_byte    = s_axis_tdata[18:11];
  assign in_char_code     = s_axis_tdata[26:19];
  assign in_pos_x         = s_axis_tdata[38:27];
  assign in_pos_y         = s_axis_tdata[50:39];
  assign in_fore_color    = s_axis_tdata[74:51];
  assign in_back_color    = s_axis_tdata[98:75];

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = cfg_reg_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pitch       <= PITCH_W'(3072);
      bytes_per_pixel <= BPP_W'(3);
      mirror_bits     <= 1'b0;
      glyph_width     <= DIM_W'(8);
      glyph_height    <= DIM_W'(8);
      glyph_stride    <= DIM_W'(8);
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_ROW_PITCH:    row_pitch       <= pwdata[PITCH_W-1:0];
        REG_BYTES_PER_PX: bytes_per_pixel <= pwdata[BPP_W-1:0];
        REG_MIRROR_BITS:  mirror_bits     <= pwdata[0];
        REG_GLYPH_WIDTH:  glyph_width     <= pwdata[DIM_W-1:0];
        REG_GLYPH_HEIGHT: glyph_height    <= pwdata[DIM_W-1:0];
        REG_GLYPH_STRIDE: glyph_stride    <= pwdata[DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_ROW_PITCH:    prdata = 32'(row_pitch);
      REG_BYTES_PER_PX: prdata = 32'(bytes_per_pixel);
      REG_MIRROR_BITS:  prdata = 32'(mirror_bits);
      REG_GLYPH_WIDTH:  prdata = 32'(glyph_width);
      REG_GLYPH_HEIGHT: prdata = 32'(glyph_height);
      REG_GLYPH_STRIDE: prdata = 32'(glyph_stride);
      default:          prdata = '0;
    endcase
  end

  // glyph size saturated to the supported maximum
  always_comb begin
    w_eff = (glyph_width > DIM_W'(MAX_GLYPH_WIDTH)) ? CW'(MAX_GLYPH_WIDTH)
                                                   : CW'(glyph_width);
    h_eff = (glyph_height > DIM_W'(MAX_GLYPH_HEIGHT)) ? RW'(MAX_GLYPH_HEIGHT)
                                                     : RW'(glyph_height);
  end

  // codes past the character count fold back once
  assign code_mod = ({1'b0, in_char_code} >= 9'(CHAR_COUNT))
                  ? CODE_W'({1'b0, in_char_code} - 9'(CHAR_COUNT))
                  : in_char_code;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign draw_go       = accept && in_action && (w_eff != '0) && (h_eff != '0);
  assign emit          = (state == ST_RUN) && (!out_valid || m_axis_tready);
  assign col_last      = (CW'(col + CW'(1)) == w_eff);
  assign row_last      = (RW'(row + RW'(1)) == h_eff);
  assign pix_last      = col_last && row_last;

  assign col3    = 3'(col);
  assign bit_idx = mirror_bits ? (BIT_MSB - col3) : col3;
  assign pix_on  = row_bits[bit_idx];

  always_comb begin
    off_ctl.en = 1'b0;
    off_ctl.op = OP_MUL;
    if (draw_go) begin
      off_ctl.en = 1'b1;
      off_ctl.op = OP_MUL;
    end else if (state == ST_BASE) begin
      off_ctl.en = 1'b1;
      off_ctl.op = OP_BASE;
    end else if (emit && !pix_last) begin
      off_ctl.en = 1'b1;
      off_ctl.op = col_last ? OP_ROW : OP_COL;
    end
  end

  // next row byte is fetched as the previous row finishes
  assign st_re    = (state == ST_BASE) || (emit && col_last && !row_last);
  assign st_raddr = (state == ST_BASE) ? char_base : STORE_AW'(glyph_addr + 1'b1);

  gpe_glyph_store u_store (
    .clk   (clk),
    .we    (accept && !in_action),
    .waddr (in_store_address),
    .wdata (in_store_byte),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (row_bits)
  );

  gpe_offset_unit u_offset (
    .clk             (clk),
    .ctl             (off_ctl),
    .pos_x           (in_pos_x),
    .pos_y           (in_pos_y),
    .bytes_per_pixel (bytes_per_pixel),
    .row_pitch       (row_pitch),
    .offset          (cur_offset)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      col       <= '0;
      row       <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (draw_go) begin
            char_base  <= STORE_AW'(code_mod * glyph_stride);
            fore_color <= in_fore_color;
            back_color <= in_back_color;
            state      <= ST_BASE;
          end
        end
        ST_BASE: begin
          glyph_addr <= char_base;
          col        <= '0;
          row        <= '0;
          state      <= ST_RUN;
        end
        ST_RUN: begin
          if (emit) begin
            out_offset <= cur_offset;
            out_color  <= pix_on ? fore_color : back_color;
            out_last   <= pix_last;
            if (pix_last) begin
              state <= ST_IDLE;
            end else if (col_last) begin
              col        <= '0;
              row        <= RW'(row + RW'(1));
              glyph_addr <= STORE_AW'(glyph_addr + 1'b1);
            end else begin
              col <= CW'(col + CW'(1));
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'b0, out_color, out_offset};
  assign m_axis_tlast  = out_last;

endmodule

`default_nettype wire

@@ tb/tb_glyph_pixel_expander_top.sv @@
// ----------------------------------------------------------------------------
// tb_glyph_pixel_expander_top
// self-checking bench for the glyph pixel expander
// ----------------------------------------------------------------------------
// Glyph rows are loaded before every draw. Draw and load words are fed
// through the input stream with random gaps. An in-bench model predicts each
// pixel word, and the output stream is checked word by word under random
// back-pressure. The run steps through several register settings: the
// extremes, zero and oversized glyphs, store address wrap and offset wrap.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_glyph_pixel_expander_top;
  import gpe_pkg::*;

  localparam int MAX_W       = 8;
  localparam int MAX_H       = 8;
  localparam int IDLE_LIMIT  = 2000;
  localparam int SETTLE_CYC  = 8;

  typedef struct packed {
    logic [23:0] bg;
    logic [23:0] fg;
    logic [11:0] y;
    logic [11:0] x;
    logic [7:0]  code;
    logic [7:0]  data;
    logic [10:0] addr;
  } glyph_word_t;

  typedef struct packed {
    logic        act;
    glyph_word_t w;
  } glyph_cmd_t;

  typedef struct packed {
    logic [23:0] color;
    logic [26:0] offset;
  } pixel_word_t;

  typedef struct packed {
    logic        last;
    pixel_word_t px;
  } pixel_t;

  typedef struct {
    logic [14:0] pitch;
    logic [2:0]  bpp;
    logic        mirror;
    logic [3:0]  width;
    logic [3:0]  height;
    logic [3:0]  stride;
  } raster_cfg_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [103:0]  s_axis_tdata = '0;
  logic [0:0]    s_axis_tuser = '0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [55:0]   m_axis_tdata;
  logic          m_axis_tlast;
  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [4:0]    paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;

  glyph_pixel_expander_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  raster_cfg_t cfg = '{15'd3072, 3'd3, 1'b0, 4'd8, 4'd8, 4'd8};
  logic [7:0]  font_mem [STORE_DEPTH];
  bit          glyph_loaded [STORE_DEPTH];
  glyph_cmd_t  cmd_q [$];
  pixel_t      pixel_q [$];

  int items_queued = 0;
  int loads_taken = 0;
  int draws_taken = 0;
  int pixels_seen = 0;
  int cfg_writes = 0;
  int err_count = 0;
  int idle_cycles = 0;

  // ---------------------------------------------------------------- model
  function automatic int unsigned eff_dim(logic [3:0] v, int unsigned lim);
    return (v > lim) ? lim : v;
  endfunction

  task automatic expand_glyph(glyph_cmd_t c);
    int unsigned ww, hh, r, col, k, bitpos;
    logic [10:0] a;
    logic [7:0]  row_bits;
    longint unsigned off;
    pixel_t p;
    if (!c.act) begin
      font_mem[c.w.addr] = c.w.data;
      return;
    end
    ww = eff_dim(cfg.width, MAX_W);
    hh = eff_dim(cfg.height, MAX_H);
    k = 0;
    for (r = 0; r < hh; r++) begin
      a = 11'(c.w.code * cfg.stride + r);
      row_bits = font_mem[a];
      for (col = 0; col < ww; col++) begin
        bitpos = cfg.mirror ? (BIT_MSB - col) : col;
        off = (longint'(c.w.x) + col) * cfg.bpp + (longint'(c.w.y) + r) * cfg.pitch;
        p.px.offset = off[26:0];
        p.px.color = row_bits[bitpos] ? c.w.fg : c.w.bg;
        p.last = (k + 1 == ww * hh);
        pixel_q.push_back(p);
        k++;
      end
    end
  endtask

  // ---------------------------------------------------------------- stimulus
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic push_load(logic [10:0] a, logic [7:0] b);
    glyph_cmd_t p;
    logic [127:0] noise;
    noise = {$urandom(), $urandom(), $urandom(), $urandom()};
    p.w = noise[98:0];
    p.act = 1'b0;
    p.w.addr = a;
    p.w.data = b;
    glyph_loaded[a] = 1'b1;
    cmd_q.push_back(p);
    items_queued++;
  endtask

  // loads whatever rows of the glyph are missing (all of them if fresh)
  task automatic push_draw(logic [7:0] code, logic [11:0] x, logic [11:0] y,
                           logic [23:0] fg, logic [23:0] bg, bit fresh);
    glyph_cmd_t p;
    logic [127:0] noise;
    int unsigned ww, hh, r;
    logic [10:0] a;
    ww = eff_dim(cfg.width, MAX_W);
    hh = eff_dim(cfg.height, MAX_H);
    if (ww != 0 && hh != 0) begin
      for (r = 0; r < hh; r++) begin
        a = 11'(code * cfg.stride + r);
        if (fresh || !glyph_loaded[a]) push_load(a, 8'($urandom_range(0, 255)));
      end
    end
    noise = {$urandom(), $urandom(), $urandom(), $urandom()};
    p.w = noise[98:0];
    p.act = 1'b1;
    p.w.code = code;
    p.w.x = x;
    p.w.y = y;
    p.w.fg = fg;
    p.w.bg = bg;
    cmd_q.push_back(p);
    items_queued++;
  endtask

  task automatic fill_random(int n);
    int stop_at, sel;
    stop_at = items_queued + n;
    while (items_queued < stop_at) begin
      sel = $urandom_range(0, 9);
      if (sel < 2)
        push_load(11'($urandom_range(0, 2047)), 8'($urandom_range(0, 255)));
      else
        push_draw(8'($urandom_range(0, 255)), 12'($urandom_range(0, 4095)),
                  12'($urandom_range(0, 4095)), 24'($urandom()), 24'($urandom()),
                  sel >= 5);
    end
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_ROW_PITCH:    cfg.pitch = val[14:0];
      REG_BYTES_PER_PX: cfg.bpp = val[2:0];
      REG_MIRROR_BITS:  cfg.mirror = val[0];
      REG_GLYPH_WIDTH:  cfg.width = val[3:0];
      REG_GLYPH_HEIGHT: cfg.height = val[3:0];
      REG_GLYPH_STRIDE: cfg.stride = val[3:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // wait for every queued word to be taken and every pixel to arrive
  task automatic drain();
    while (cmd_q.size() != 0 || s_axis_tvalid || pixel_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic run_phase(int pitch, int bpp, int mirror, int w, int h, int stride,
                           int n);
    drain();
    write_reg(REG_ROW_PITCH, pitch);
    write_reg(REG_BYTES_PER_PX, bpp);
    write_reg(REG_MIRROR_BITS, mirror);
    write_reg(REG_GLYPH_WIDTH, w);
    write_reg(REG_GLYPH_HEIGHT, h);
    write_reg(REG_GLYPH_STRIDE, stride);
    push_draw(8'hFF, 12'hFFF, 12'hFFF, 24'hFFFFFF, 24'h000000, 1'b1);
    push_draw(8'h00, 12'h000, 12'h000, 24'h000000, 24'hFFFFFF, 1'b1);
    fill_random(n);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // default settings: hand-picked row patterns and corner positions
    push_load(11'd0, 8'hFF);
    push_load(11'd1, 8'h00);
    push_load(11'd2, 8'h01);
    push_load(11'd3, 8'h80);
    push_load(11'd4, 8'hAA);
    push_load(11'd5, 8'h55);
    push_load(11'd6, 8'h0F);
    push_load(11'd7, 8'hF0);
    push_draw(8'h00, 12'h000, 12'h000, 24'hFFFFFF, 24'h000000, 1'b0);
    push_draw(8'h00, 12'hFFF, 12'hFFF, 24'h000000, 24'hFFFFFF, 1'b0);
    push_draw(8'hFF, 12'hFFF, 12'h000, 24'hA5A5A5, 24'h5A5A5A, 1'b1);
    fill_random(40);

    // 1x1 glyphs, mirrored, zero pitch
    run_phase(0, 3, 1, 1, 1, 1, 30);
    // oversized glyph, store address and offset wrap
    run_phase(32767, 7, 0, 15, 15, 15, 30);
    run_phase(16384, 4, 1, 8, 8, 8, 30);
    // zero width, then zero height: draws give no pixels
    run_phase(1000, 0, 0, 0, 5, 3, 30);
    run_phase(200, 2, 1, 6, 0, 2, 30);
    // every character shares the same rows
    run_phase(4095, 1, 0, 9, 3, 0, 30);
    repeat (4) begin
      run_phase($urandom_range(0, 32767), $urandom_range(0, 7), $urandom_range(0, 1),
                $urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(0, 15), 30);
    end

    drain();
    if (pixel_q.size() != 0) err_count++;
    $display("covered %0d loads, %0d draws and %0d checked pixel words",
             loads_taken, draws_taken, pixels_seen);
    $display("over %0d register writes; %0d bad words", cfg_writes, err_count);
    if (err_count == 0) begin
      $display("glyph_pixel_expander_top test passed");
    end else begin
      $display("glyph_pixel_expander_top test failed");
    end
    $finish;
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
    $display("glyph_pixel_expander_top test failed");
    $finish;
  end

  // ---------------------------------------------------------------- driver
  glyph_cmd_t cur_cmd;
  logic       in_taken = 1'b0;
  int         send_gap = 0;
  int         send_calm = 0;
  int         hold_left = 0;
  int         recv_calm = 0;

  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !in_taken) begin
      // word still waiting for the block
    end else if (send_gap > 0) begin
      s_axis_tvalid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (cmd_q.size() != 0) begin
      cur_cmd = cmd_q.pop_front();
      s_axis_tvalid <= 1'b1;
      s_axis_tdata <= {5'b0, cur_cmd.w};
      s_axis_tuser <= cur_cmd.act;
      if (send_calm > 0) begin
        send_calm <= send_calm - 1;
        send_gap <= 0;
      end else begin
        send_gap <= pick_gap();
        if ($urandom_range(0, 49) == 0) send_calm <= $urandom_range(20, 80);
      end
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if (recv_calm > 0) begin
        recv_calm <= recv_calm - 1;
      end else if ($urandom_range(0, 3) == 0) begin
        hold_left <= pick_gap();
        if ($urandom_range(0, 19) == 0) recv_calm <= $urandom_range(40, 200);
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin : mon_blk
    pixel_word_t got;
    pixel_t      want;
    glyph_cmd_t  taken;
    bit          moved;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= s_axis_tvalid && s_axis_tready;
      moved = (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
              (psel && penable && pwrite && pready);
      idle_cycles <= moved ? 0 : idle_cycles + 1;

      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[50:0];
        pixels_seen++;
        if (pixel_q.size() == 0) begin
          if (err_count < 10)
            $display("unexpected pixel word: offset %h colour %h last %b",
                     got.offset, got.color, m_axis_tlast);
          err_count++;
        end else begin
          want = pixel_q.pop_front();
          if (got.offset !== want.px.offset || got.color !== want.px.color ||
              m_axis_tlast !== want.last) begin
            if (err_count < 10)
              $display("pixel %0d: expected offset %h colour %h last %b, got %h %h %b",
                       pixels_seen, want.px.offset, want.px.color, want.last,
                       got.offset, got.color, m_axis_tlast);
            err_count++;
          end
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        taken.act = s_axis_tuser[0];
        taken.w = s_axis_tdata[98:0];
        if (taken.act) draws_taken++;
        else loads_taken++;
        expand_glyph(taken);
      end
    end
  end

endmodule
